FILE: rtl/core/point_in_polygon_test_core_macros.svh
// Assertion helpers for the point-in-polygon core.
`ifndef POINT_IN_POLYGON_TEST_CORE_MACROS_SVH
`define POINT_IN_POLYGON_TEST_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PIPT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pipt assertion failed");
// next-cycle implication
`define PIPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pipt assertion failed");
`else
`define PIPT_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PIPT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/pipt_pkg.sv
package pipt_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_WIDTH_DEF  = 16;
   localparam int MIN_VERTICES     = 3;

   localparam int FIELD_WIDTH      = 16;
   localparam int SLOT_WIDTH       = 6;
   localparam int COUNT_WIDTH      = 7;
   localparam int TOL_WIDTH        = 32;
   localparam int CSR_INDEX_WIDTH  = 1;
   localparam int CSR_DATA_WIDTH   = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERTEX_COUNT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE    = 1'd1;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                          op;
      logic [SLOT_WIDTH-1:0]         vertex_index;
      logic signed [FIELD_WIDTH-1:0] point_x;
      logic signed [FIELD_WIDTH-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic inside_or_on;
      logic on_edge;
   } rsp_type;

   // read tag aligned with the vertex memory's read data
   typedef struct packed {
      logic rd_valid;
      logic edge_valid;
      logic last;
   } edge_tag_type;

   typedef struct packed {
      logic valid;
      logic last;
   } stage_tag_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic hit;
      logic toggle;
   } edge_res_type;

endpackage

FILE: rtl/core/point_in_polygon_test_core.sv
// Channel  Handshake          Payload               Moves
// -------  -----------------  --------------------  -------------------------------------
// req      req_valid/ready    pipt_pkg::req_type    vertex load or query point
// rsp      rsp_valid/ready    pipt_pkg::rsp_type    one verdict per query
// csr      csr_valid/ready    csr_index, csr_wdata  vertex_count, tolerance
//
// Loads transfer back to back, one slot write each. A query reads one edge per
// cycle, then waits in DONE for the output register; the next request can
// transfer once the verdict is valid. With fewer than three vertices the query
// skips the walk and goes straight to DONE.
// Reset (synchronous) clears control and CSRs, not the point, rsp data or vertex RAM.
// A stalled rsp holds its verdict; a following query walks, then waits in DONE.
`include "point_in_polygon_test_core_macros.svh"

module point_in_polygon_test_core #(
   parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = pipt_pkg::COORD_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  pipt_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output pipt_pkg::rsp_type                       rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pipt_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [pipt_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import pipt_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int NW = $clog2(MAX_VERTICES + 1);
   localparam int CB = (COORD_WIDTH < FIELD_WIDTH) ? COORD_WIDTH : FIELD_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                     state_ff, state_in;

   // configuration registers
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic [TOL_WIDTH-1:0]          tol_ff, tol_in;

   // query context
   logic [NW-1:0]                 n_ff, n_in, n_eff;
   logic signed [COORD_WIDTH-1:0] px_ff, py_ff, px_in, py_in, x_c, y_c;

   // read sequencer
   logic                          issue_ff, issue_in;
   logic [NW-1:0]                 k_ff, k_in, addr_full;
   edge_tag_type                  tag_ff, tag_in;

   // accumulators and output register
   logic                          hit_acc_ff, hit_acc_in, par_ff, par_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_data_ff, rsp_data_in;

   logic                          req_fire, load_fire, query_fire, slot_ok;
   logic                          mem_wr_en;
   logic [AW-1:0]                 mem_wr_addr, mem_rd_addr;
   logic [2*COORD_WIDTH-1:0]      mem_wr_data, mem_rd_data;
   logic signed [COORD_WIDTH-1:0] vx, vy;
   edge_res_type                  res;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign load_fire  = req_fire && (req_data.op == OP_LOAD);
   assign query_fire = req_fire && (req_data.op == OP_QUERY);
   assign csr_ready  = 1'b1;

   // coordinates keep the low CB bits of the field, sign-extended
   assign x_c = COORD_WIDTH'(signed'(req_data.point_x[CB-1:0]));
   assign y_c = COORD_WIDTH'(signed'(req_data.point_y[CB-1:0]));

   // drop loads that aim past the end of the table
   assign slot_ok     = 32'(req_data.vertex_index) < 32'(MAX_VERTICES);
   assign mem_wr_en   = load_fire && slot_ok;
   assign mem_wr_addr = AW'(req_data.vertex_index);
   assign mem_wr_data = {x_c, y_c};

   // clamp the vertex count to the table size
   assign n_eff = (32'(count_ff) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                       : NW'(count_ff);

   // read order: last vertex first, then 0 .. n-1
   assign addr_full   = (k_ff == '0) ? n_ff - NW'(1) : k_ff - NW'(1);
   assign mem_rd_addr = addr_full[AW-1:0];

   assign vx = signed'(mem_rd_data[2*COORD_WIDTH-1:COORD_WIDTH]);
   assign vy = signed'(mem_rd_data[COORD_WIDTH-1:0]);

   // configuration writes
   always_comb begin
      count_in = count_ff;
      tol_in   = tol_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VERTEX_COUNT: count_in = csr_wdata[COUNT_WIDTH-1:0];
            CSR_TOLERANCE:    tol_in   = csr_wdata[TOL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // main control
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      issue_in     = issue_ff;
      k_in         = k_ff;
      hit_acc_in   = hit_acc_ff;
      par_in       = par_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      tag_in.rd_valid   = issue_ff;
      tag_in.edge_valid = (k_ff != '0);
      tag_in.last       = (k_ff == n_ff);

      // retire a transfer on the result side
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (query_fire) begin
               n_in       = n_eff;
               px_in      = x_c;
               py_in      = y_c;
               hit_acc_in = 1'b0;
               par_in     = 1'b0;
               k_in       = '0;
               if (32'(n_eff) < MIN_VERTICES) begin
                  state_in = ST_DONE;
               end else begin
                  issue_in = 1'b1;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (issue_ff) begin
               k_in = k_ff + NW'(1);
               if (k_ff == n_ff) begin
                  issue_in = 1'b0;
               end
            end
            if (res.valid) begin
               hit_acc_in = hit_acc_ff | res.hit;
               par_in     = par_ff ^ res.toggle;
               if (res.last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.inside_or_on = hit_acc_ff | par_ff;
               rsp_data_in.on_edge      = hit_acc_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         tol_ff       <= '0;
         issue_ff     <= 1'b0;
         k_ff         <= '0;
         tag_ff       <= '0;
         hit_acc_ff   <= 1'b0;
         par_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tol_ff       <= tol_in;
         issue_ff     <= issue_in;
         k_ff         <= k_in;
         tag_ff       <= tag_in;
         hit_acc_ff   <= hit_acc_in;
         par_ff       <= par_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pipt_vertex_mem #(
      .DEPTH (MAX_VERTICES),
      .WIDTH (2 * COORD_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (issue_ff),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pipt_edge_unit #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_edge (
      .clock     (clock),
      .reset     (reset),
      .tag       (tag_ff),
      .vx        (vx),
      .vy        (vy),
      .px        (px_ff),
      .py        (py_ff),
      .tolerance (tol_ff),
      .res       (res)
   );

   `PIPT_ASSERT_NEXT(a_rsp_from_done, clock, reset, !rsp_valid_ff && (state_ff != ST_DONE), !rsp_valid_ff)
   `PIPT_ASSERT_NOW(a_res_in_walk, clock, reset, res.valid, state_ff == ST_WALK)
   `PIPT_ASSERT_NOW(a_issue_in_walk, clock, reset, issue_ff, state_ff == ST_WALK)
   `PIPT_ASSERT_NEXT(a_query_busy, clock, reset, query_fire, state_ff != ST_IDLE)

endmodule

FILE: rtl/core/pipt_vertex_mem.sv
module pipt_vertex_mem #(
   parameter int DEPTH = pipt_pkg::MAX_VERTICES_DEF,
   parameter int WIDTH = 2 * pipt_pkg::COORD_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/pipt_edge_unit.sv
module pipt_edge_unit #(
   parameter int COORD_WIDTH = pipt_pkg::COORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pipt_pkg::edge_tag_type              tag,
   input  logic signed [COORD_WIDTH-1:0]       vx,
   input  logic signed [COORD_WIDTH-1:0]       vy,
   input  logic signed [COORD_WIDTH-1:0]       px,
   input  logic signed [COORD_WIDTH-1:0]       py,
   input  logic [pipt_pkg::TOL_WIDTH-1:0]      tolerance,
   output pipt_pkg::edge_res_type              res
);
   import pipt_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int CW = (PW + 2 > TOL_WIDTH + 2) ? PW + 2 : TOL_WIDTH + 2;

   // previous vertex (edge end b); current read vertex is edge end a
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff, prev_x_in, prev_y_in;

   // stage 1: differences
   logic signed [DW-1:0] apx_ff, apy_ff, abx_ff, aby_ff;
   logic signed [DW-1:0] apx_in, apy_in, abx_in, aby_in;
   logic                 straddle1_ff, straddle1_in, dpos1_ff, dpos1_in;
   stage_tag_type        tag1_ff, tag1_in;

   // stage 2: products
   logic signed [PW-1:0] cr1_ff, cr2_ff, dt1_ff, dt2_ff, ln1_ff, ln2_ff;
   logic signed [PW-1:0] cr1_in, cr2_in, dt1_in, dt2_in, ln1_in, ln2_in;
   logic                 straddle2_ff, dpos2_ff;
   stage_tag_type        tag2_ff;

   // stage 3: sums
   logic signed [CW-1:0] cross_ff, dot_ff, len2_ff, cross_in, dot_in, len2_in;
   logic                 straddle3_ff, dpos3_ff;
   stage_tag_type        tag3_ff;

   // stage 4: decisions
   edge_res_type         res_ff, res_in;
   logic signed [CW-1:0] tol_s;

   assign tol_s = signed'(CW'(tolerance));

   always_comb begin
      prev_x_in    = tag.rd_valid ? vx : prev_x_ff;
      prev_y_in    = tag.rd_valid ? vy : prev_y_ff;
      apx_in       = DW'(px) - DW'(vx);
      apy_in       = DW'(py) - DW'(vy);
      abx_in       = DW'(prev_x_ff) - DW'(vx);
      aby_in       = DW'(prev_y_ff) - DW'(vy);
      straddle1_in = (vy > py) != (prev_y_ff > py);
      dpos1_in     = prev_y_ff > vy;
      tag1_in.valid = tag.rd_valid && tag.edge_valid;
      tag1_in.last  = tag.last;
   end

   always_comb begin
      cr1_in = PW'(apx_ff) * PW'(aby_ff);
      cr2_in = PW'(apy_ff) * PW'(abx_ff);
      dt1_in = PW'(apx_ff) * PW'(abx_ff);
      dt2_in = PW'(apy_ff) * PW'(aby_ff);
      ln1_in = PW'(abx_ff) * PW'(abx_ff);
      ln2_in = PW'(aby_ff) * PW'(aby_ff);
   end

   always_comb begin
      cross_in = CW'(cr1_ff) - CW'(cr2_ff);
      dot_in   = CW'(dt1_ff) + CW'(dt2_ff);
      len2_in  = CW'(ln1_ff) + CW'(ln2_ff);
   end

   always_comb begin
      res_in.valid  = tag3_ff.valid;
      res_in.last   = tag3_ff.last;
      res_in.hit    = (cross_ff <= tol_s) && (cross_ff >= -tol_s) &&
                      (dot_ff >= -tol_s) && (dot_ff <= len2_ff + tol_s);
      // strictly left of the edge at the point's height
      res_in.toggle = straddle3_ff &&
                      (dpos3_ff ? cross_ff[CW-1]
                                : (!cross_ff[CW-1] && (cross_ff != '0)));
   end

   always_ff @(posedge clock) begin
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      apx_ff       <= apx_in;
      apy_ff       <= apy_in;
      abx_ff       <= abx_in;
      aby_ff       <= aby_in;
      straddle1_ff <= straddle1_in;
      dpos1_ff     <= dpos1_in;
      cr1_ff       <= cr1_in;
      cr2_ff       <= cr2_in;
      dt1_ff       <= dt1_in;
      dt2_ff       <= dt2_in;
      ln1_ff       <= ln1_in;
      ln2_ff       <= ln2_in;
      straddle2_ff <= straddle1_ff;
      dpos2_ff     <= dpos1_ff;
      cross_ff     <= cross_in;
      dot_ff       <= dot_in;
      len2_ff      <= len2_in;
      straddle3_ff <= straddle2_ff;
      dpos3_ff     <= dpos2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         res_ff  <= '0;
      end else begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         res_ff  <= res_in;
      end
   end

   assign res = res_ff;

endmodule
